FILE: design/ble_pkg.sv
// ---------------------------------------------------------------------------
// ble_pkg - shared definitions for the bounded ordered list engine
// holds sizes, opcodes, status codes and the cell command bundle
// ---------------------------------------------------------------------------
package ble_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef logic signed [VALUE_WIDTH-1:0] entry_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [CNT_W-1:0]              cnt_t;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_DEL_FRONT = 3'd1,
        OP_DEL_BACK  = 3'd2,
        OP_DEL_POS   = 3'd3,
        OP_DEL_KEY   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BADPOS = 3'd2,
        ST_NOKEY  = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;      // shift toward the back, value enters the front
        logic   del_pos;  // cells at or behind pos_idx pull from the back
        logic   del_key;  // cells at or behind the first match pull from the back
        idx_t   pos_idx;
        entry_t value;
        cnt_t   count;
    } cell_cmd_t;

    // narrow or sign-extend the 32-bit operand to the stored width
    function automatic entry_t to_entry(input logic signed [31:0] v);
        return entry_t'(v);
    endfunction

endpackage

FILE: design/bounded_ordered_list_engine.sv
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine - ordered list of signed values in a cell chain
// insert at front, delete front/back/at position/by key, one status per item
// ---------------------------------------------------------------------------
// usage:
//   s_ channel carries one command item: opcode, operand value, position
//   m_ channel returns one result item per command: status, list length
//   every command is applied to the whole chain at once: all cells compare against
//   the key and shift toward or away from the front at the same edge
//   m_tvalid rises in the cycle after an item is accepted, and one item can be
//   accepted every cycle while the receiver keeps m_tready high
//   the result sits in an output register; while it is stalled s_tready
//   follows m_tready, so a new item is taken in the cycle the old result
//   leaves
//   the key search runs as a match chain through the cells, the first
//   match nearest the front removes itself and everything behind it
//   pulls forward by one
//   reset clears the length and the output valid; entry contents stay
//   undefined and are never read beyond the length
// ---------------------------------------------------------------------------
module bounded_ordered_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] opcode, [34:3] operand_value, [42:35] position, [47:43] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [7:3] list_length
    output logic [7:0]  m_tdata
);

    localparam int CMP_W = (ble_pkg::CNT_W > 8) ? ble_pkg::CNT_W : 8;

    // input fields
    logic [2:0]         in_opcode;
    logic signed [31:0] in_value;
    logic [7:0]         in_position;

    assign in_opcode   = s_tdata[2:0];
    assign in_value    = s_tdata[34:3];
    assign in_position = s_tdata[42:35];

    // control state
    ble_pkg::cnt_t count_reg;
    ble_pkg::cnt_t count_next;
    logic          m_tvalid_reg;
    logic [7:0]    m_tdata_reg;

    logic               accept;
    ble_pkg::status_t   status_next;
    ble_pkg::cell_cmd_t cmd;
    logic               empty;
    logic               full;
    logic               pos_ok;
    logic               key_found;
    logic [CMP_W-1:0]   pos_cmp;
    logic [CMP_W-1:0]   cnt_cmp;

    // chain wiring
    ble_pkg::entry_t entries     [ble_pkg::DEPTH];
    logic            match_chain [ble_pkg::DEPTH+1];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == ble_pkg::CNT_W'(ble_pkg::DEPTH));
    assign pos_cmp = CMP_W'(in_position);
    assign cnt_cmp = CMP_W'(count_reg);
    assign pos_ok  = (pos_cmp != '0) && (pos_cmp <= cnt_cmp);

    // key found when the match chain carries a hit out of the last cell
    assign key_found = match_chain[ble_pkg::DEPTH];

    // decode the command and work out status and the new length
    always_comb begin
        cmd.ins     = 1'b0;
        cmd.del_pos = 1'b0;
        cmd.del_key = 1'b0;
        cmd.pos_idx = '0;
        cmd.value   = ble_pkg::to_entry(in_value);
        cmd.count   = count_reg;
        status_next = ble_pkg::ST_DONE;
        count_next  = count_reg;

        unique case (in_opcode)
            ble_pkg::OP_INS_FRONT: begin
                if (full) begin
                    status_next = ble_pkg::ST_FULL;
                end else begin
                    cmd.ins    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            ble_pkg::OP_DEL_FRONT: begin
                if (empty) begin
                    status_next = ble_pkg::ST_EMPTY;
                end else begin
                    // delete front is delete at the first slot
                    cmd.del_pos = accept;
                    count_next  = count_reg - 1'b1;
                end
            end
            ble_pkg::OP_DEL_BACK: begin
                if (empty) begin
                    status_next = ble_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            ble_pkg::OP_DEL_POS: begin
                if (empty) begin
                    status_next = ble_pkg::ST_EMPTY;
                end else if (!pos_ok) begin
                    status_next = ble_pkg::ST_BADPOS;
                end else begin
                    cmd.del_pos = accept;
                    cmd.pos_idx = ble_pkg::IDX_W'(in_position - 8'd1);
                    count_next  = count_reg - 1'b1;
                end
            end
            ble_pkg::OP_DEL_KEY: begin
                if (empty) begin
                    status_next = ble_pkg::ST_EMPTY;
                end else if (!key_found) begin
                    status_next = ble_pkg::ST_NOKEY;
                end else begin
                    cmd.del_key = accept;
                    count_next  = count_reg - 1'b1;
                end
            end
            default: begin
                // unused opcodes leave everything as it is
                status_next = ble_pkg::ST_DONE;
            end
        endcase
    end

    // the cell chain: front is cell 0, each cell sees both neighbors
    assign match_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < ble_pkg::DEPTH; gi++) begin : g_cell
            ble_pkg::entry_t left_e;
            ble_pkg::entry_t right_e;

            if (gi == 0) begin : g_front
                assign left_e = cmd.value;
            end else begin : g_mid_l
                assign left_e = entries[gi-1];
            end

            if (gi == ble_pkg::DEPTH - 1) begin : g_back
                assign right_e = entries[gi];
            end else begin : g_mid_r
                assign right_e = entries[gi+1];
            end

            ble_cell u_cell (
                .aclk        (aclk),
                .cell_index  (ble_pkg::IDX_W'(gi)),
                .cmd         (cmd),
                .left_entry  (left_e),
                .right_entry (right_e),
                .match_in    (match_chain[gi]),
                .match_out   (match_chain[gi+1]),
                .entry_out   (entries[gi])
            );
        end
    endgenerate

    // length and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {5'(count_next), status_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // length never passes the list size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ble_pkg::CNT_W'(ble_pkg::DEPTH))
        else $error("list length beyond depth");

    // every accepted item yields a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("no result after accepted item");

    // a successful insert grows the list by one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_opcode == ble_pkg::OP_INS_FRONT)
         && (status_next == ble_pkg::ST_DONE))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the list");

    // a stalled result freezes the list length
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(count_reg))
        else $error("list changed during output stall");

    // the reported length matches the held length
    a_length_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] == 5'(count_reg)))
        else $error("reported length differs from list length");

endmodule

FILE: design/ble_cell.sv
// ---------------------------------------------------------------------------
// ble_cell - one list slot of the chain
// holds one entry, matches it against the key and shifts with its neighbors
// ---------------------------------------------------------------------------
module ble_cell (
    input  logic                aclk,
    input  ble_pkg::idx_t       cell_index,
    input  ble_pkg::cell_cmd_t  cmd,
    input  ble_pkg::entry_t     left_entry,
    input  ble_pkg::entry_t     right_entry,
    input  logic                match_in,
    output logic                match_out,
    output ble_pkg::entry_t     entry_out
);

    ble_pkg::entry_t entry_reg;
    ble_pkg::entry_t entry_next;
    logic            occupied;
    logic            remove;

    assign occupied  = ble_pkg::CNT_W'(cell_index) < cmd.count;
    assign match_out = match_in | (occupied && (entry_reg == cmd.value));
    assign remove    = (cmd.del_pos && (cell_index >= cmd.pos_idx))
                     || (cmd.del_key && match_out);
    assign entry_out = entry_reg;

    always_comb begin
        priority if (cmd.ins) begin
            entry_next = left_entry;
        end else if (remove) begin
            entry_next = right_entry;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

FILE: tb/ble_list_checker.sv
// ---------------------------------------------------------------------------
// ble_list_checker - result checker for the bounded ordered list engine
// mirrors the list from accepted command items and checks every result item
// ---------------------------------------------------------------------------
module ble_list_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [2:0] opcode, [34:3] operand_value, [42:35] position, [47:43] zero
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [7:3] list_length
    input  logic [7:0]  m_tdata,
    output int          mismatch_count,
    output int          results_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        ble_pkg::status_t status;
        logic [4:0]       length;
    } list_result_t;

    ble_pkg::entry_t shadow_list [ble_pkg::DEPTH];
    int              shadow_len;
    list_result_t    owed_results [$];

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
        shadow_len     = 0;
    end

    // apply one command to the shadow list, return its status
    function automatic ble_pkg::status_t list_apply_op(input logic [2:0] op,
                                                       input ble_pkg::entry_t val,
                                                       input logic [7:0] pos);
        int hit;
        hit = -1;
        if (op == ble_pkg::OP_INS_FRONT) begin
            if (shadow_len >= ble_pkg::DEPTH)
                return ble_pkg::ST_FULL;
            for (int k = ble_pkg::DEPTH - 1; k > 0; k--)
                shadow_list[k] = shadow_list[k-1];
            shadow_list[0] = val;
            shadow_len++;
            return ble_pkg::ST_DONE;
        end
        // spare opcodes do nothing
        if (op > ble_pkg::OP_DEL_KEY)
            return ble_pkg::ST_DONE;
        if (shadow_len == 0)
            return ble_pkg::ST_EMPTY;
        case (op)
            ble_pkg::OP_DEL_FRONT: hit = 0;
            ble_pkg::OP_DEL_BACK:  hit = shadow_len - 1;
            ble_pkg::OP_DEL_POS: begin
                if (pos == 0 || int'(pos) > shadow_len)
                    return ble_pkg::ST_BADPOS;
                hit = int'(pos) - 1;
            end
            default: begin
                // first match from the front wins
                for (int k = 0; k < shadow_len; k++) begin
                    if (shadow_list[k] == val) begin
                        hit = k;
                        break;
                    end
                end
                if (hit < 0)
                    return ble_pkg::ST_NOKEY;
            end
        endcase
        for (int k = hit; k < ble_pkg::DEPTH - 1; k++)
            shadow_list[k] = shadow_list[k+1];
        shadow_len--;
        return ble_pkg::ST_DONE;
    endfunction

    always @(posedge aclk) begin
        list_result_t exp_res;
        list_result_t new_res;
        if (!aresetn) begin
            owed_results.delete();
            shadow_len = 0;
            for (int k = 0; k < ble_pkg::DEPTH; k++)
                shadow_list[k] = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual status %0d length %0d",
                             $time, m_tdata[2:0], m_tdata[7:3]);
                    mismatch_count++;
                end else begin
                    exp_res = owed_results.pop_front();
                    if (m_tdata[2:0] !== exp_res.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, exp_res.status, m_tdata[2:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[7:3] !== exp_res.length) begin
                        $display("%0t: length mismatch, expected %0d actual %0d",
                                 $time, exp_res.length, m_tdata[7:3]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                new_res.status = list_apply_op(s_tdata[2:0],
                                               ble_pkg::entry_t'(s_tdata[34:3]),
                                               s_tdata[42:35]);
                new_res.length = shadow_len[4:0];
                owed_results.push_back(new_res);
            end
        end
        results_owed = owed_results.size();
    end

endmodule

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench - top level for the bounded ordered list engine
// drives directed and random command items in bursts against a stalling
// receiver; the checker mirrors the list and compares every result item
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // opcodes past delete by key are spare and act as no-ops
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1880;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [2:0] opcode, [34:3] operand_value, [42:35] position, [47:43] zero
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [2:0] status, [7:3] list_length
    logic [7:0]  m_tdata;

    int mismatch_count;
    int results_owed;
    int burst_left = 8;

    // a few values that keep showing up so key deletes find matches
    logic [31:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
                                    32'h7fff_ffff, 32'h8000_0000, 32'h5a5a_5a5a,
                                    32'h0000_ffff, 32'hffff_0000};

    bounded_ordered_list_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ble_list_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 8 ns clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // receiver: alternating ready runs and stall runs of random length,
    // with an occasional long stretch of no stalls at all
    always @(posedge aclk) begin
        int run_left;
        if (run_left <= 0) begin
            if (!m_tready) begin
                m_tready <= 1'b1;
                run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 12);
            end else begin
                m_tready <= 1'b0;
                run_left = $urandom_range(1, 6);
            end
        end else begin
            run_left--;
        end
    end

    // send one command item and wait for the handshake; the handshake is
    // judged at the falling edge, where every signal has settled
    task automatic send_cmd(input logic [2:0] op, input logic [31:0] val,
                            input logic [7:0] pos);
        int   gap;
        logic taken;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, pos, val, op};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        // sender works in bursts, valid drops between them
        burst_left--;
        if (burst_left <= 0) begin
            gap        = $urandom_range(1, 7);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // half from the shared pool, half fully random
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[3'($urandom_range(0, 7))];
        return $urandom();
    endfunction

    // mostly positions that land inside or just past the list
    function automatic logic [7:0] pick_position();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, ble_pkg::DEPTH + 1));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int          mode;
        int          episode_left;
        int          roll;
        int          sent;
        logic [2:0]  op;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // every delete on an empty list reports empty, spare opcodes do nothing
        send_cmd(ble_pkg::OP_DEL_FRONT, 32'h0, 8'd1);
        send_cmd(ble_pkg::OP_DEL_BACK,  32'h0, 8'd1);
        send_cmd(ble_pkg::OP_DEL_POS,   32'h0, 8'd0);
        send_cmd(ble_pkg::OP_DEL_KEY,   32'h0, 8'd255);
        send_cmd(OP_SPARE_LO,           32'hffff_ffff, 8'd255);
        send_cmd(OP_SPARE_HI,           32'h0, 8'd0);

        // value extremes at the front
        send_cmd(ble_pkg::OP_INS_FRONT, 32'h7fff_ffff, 8'd0);
        send_cmd(ble_pkg::OP_INS_FRONT, 32'h8000_0000, 8'd255);
        send_cmd(ble_pkg::OP_INS_FRONT, 32'hffff_ffff, 8'd0);
        send_cmd(ble_pkg::OP_INS_FRONT, 32'h0000_0000, 8'd0);

        // position zero, one past the length and the top of the range
        send_cmd(ble_pkg::OP_DEL_POS, 32'h0, 8'd0);
        send_cmd(ble_pkg::OP_DEL_POS, 32'h0, 8'd5);
        send_cmd(ble_pkg::OP_DEL_POS, 32'h0, 8'd255);
        // absent key
        send_cmd(ble_pkg::OP_DEL_KEY, 32'h0001_2345, 8'd0);
        // duplicate key, the one nearest the front goes
        send_cmd(ble_pkg::OP_INS_FRONT, 32'h8000_0000, 8'd0);
        send_cmd(ble_pkg::OP_DEL_KEY,   32'h8000_0000, 8'd0);
        // last, middle, back, front
        send_cmd(ble_pkg::OP_DEL_POS,   32'h0, 8'd4);
        send_cmd(ble_pkg::OP_DEL_POS,   32'h0, 8'd2);
        send_cmd(ble_pkg::OP_DEL_BACK,  32'h0, 8'd0);
        send_cmd(ble_pkg::OP_DEL_FRONT, 32'h0, 8'd0);

        // fill to the limit, then one insert too many
        for (int k = 0; k <= ble_pkg::DEPTH; k++)
            send_cmd(ble_pkg::OP_INS_FRONT, $urandom(), 8'($urandom_range(0, 255)));

        // random part in episodes: filling, draining or mixed, so the list
        // keeps swinging between empty and full
        sent         = 0;
        episode_left = 0;
        mode         = 0;
        while (sent < RANDOM_ITEMS) begin
            if (episode_left <= 0) begin
                mode         = $urandom_range(0, 2);
                episode_left = $urandom_range(10, 60);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end else if (roll < ((mode == 0) ? 80 : (mode == 1) ? 15 : 45)) begin
                op = ble_pkg::OP_INS_FRONT;
            end else begin
                op = 3'($urandom_range(ble_pkg::OP_DEL_FRONT, ble_pkg::OP_DEL_KEY));
            end
            send_cmd(op, pick_value(), pick_position());
            sent++;
            episode_left--;
        end
        s_tvalid <= 1'b0;

        // drain: wait until every owed result has come back
        do begin
            @(negedge aclk);
        end while (results_owed != 0);
        repeat (4) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
